FILE: hw/rtl/nearest_palette_color_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest palette color block.
// Define ASSERT_OFF to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define NPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nearest_palette_color: assertion failed");
// next-cycle implication
`define NPC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nearest_palette_color: assertion failed");
`else
`define NPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define NPC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/npc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npc_pkg
// Types, palette ROM contents and helpers shared by the palette search chain.
// ---------------------------------------------------------------------------
package npc_pkg;

   localparam int NPC_ROM_DEPTH            = 64;
   localparam int NPC_PALETTE_SIZE_DEFAULT = 64;
   localparam int NPC_CHAN_W               = 8;
   localparam int NPC_INDEX_W              = 7;
   localparam int NPC_DIST_W               = 18;
   localparam int NPC_SQ_W                 = 2 * NPC_CHAN_W;
   localparam logic [NPC_DIST_W-1:0] NPC_DIST_MAX = 18'd195075;

   // entry k holds palette index k + 1, packed as R, G, B
   localparam logic [3*NPC_CHAN_W-1:0] NPC_PALETTE [NPC_ROM_DEPTH] = '{
      24'h0E1F7C, 24'h0A55A3, 24'h308777, 24'h4B6BAF,
      24'hED171F, 24'hD15C00, 24'h913697, 24'hE49ACB,
      24'h915FAC, 24'h9DD67D, 24'hE8A900, 24'hFEBA35,
      24'hFFFF00, 24'h70BC1F, 24'hBA9800, 24'hA8A8A8,
      24'h7B6F00, 24'hFFFFB3, 24'h5F6579, 24'h000000,
      24'h0B3D91, 24'h770176, 24'h293133, 24'h2A1301,
      24'hF64A8A, 24'hB27624, 24'hFCBBC4, 24'hFE370F,
      24'hF0F0F0, 24'h6A1C8A, 24'hA8DDC4, 24'h2584BB,
      24'hFEB343, 24'hF0E765, 24'hD0A660, 24'hD15400,
      24'h66BA49, 24'h134A46, 24'h6E7B77, 24'hD8CAC6,
      24'h435607, 24'hF0E1C6, 24'hF993BC, 24'h003822,
      24'hB2AFD4, 24'h686AB0, 24'hEFE3B9, 24'hF73866,
      24'hB54C64, 24'h132B1A, 24'hC70155, 24'hFE9E32,
      24'hA8DEEB, 24'h00671A, 24'h4E2990, 24'h2F7E20,
      24'hFEE3C5, 24'hFFD911, 24'h095BA6, 24'hF0F970,
      24'hE3F35B, 24'hA0A0A0, 24'hA0A0A0, 24'hA0A0A0
   };

   // one beat traveling down the chain: the pixel and the best match so far
   typedef struct packed {
      logic [NPC_CHAN_W-1:0]  red;
      logic [NPC_CHAN_W-1:0]  green;
      logic [NPC_CHAN_W-1:0]  blue;
      logic [NPC_DIST_W-1:0]  best_dist;
      logic [NPC_INDEX_W-1:0] best_index;
   } npc_beat_type;

   function automatic logic [NPC_CHAN_W-1:0] npc_abs_diff(
      input logic [NPC_CHAN_W-1:0] a,
      input logic [NPC_CHAN_W-1:0] b
   );
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: hw/rtl/nearest_palette_color.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_palette_color
// Nearest thread-color search over a fixed palette, one cell per entry.
// ---------------------------------------------------------------------------
// Usage:
//   A pixel beat (req_pixel_red/green/blue) is taken when req_valid and
//   req_ready are both high. One result beat (rsp_best_index from 1 up,
//   rsp_best_distance_sq) leaves on rsp_valid/rsp_ready for every pixel, in
//   order. The index is the nearest palette entry; on a tie the highest
//   index wins.
//   The pixel walks a chain of min(PALETTE_SIZE, 64) cells, each one
//   register stage, moving one cell per cycle while the chain advances;
//   rsp_valid is the last cell's valid flag. Throughput is one pixel per
//   cycle unless the receiver stalls, set by one cell's add and compare.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and req_ready drops in the same cycle; it rises again as soon as the
//   waiting result is taken. Reset empties the chain; the palette is ROM
//   and needs no reset.
// ---------------------------------------------------------------------------
`include "nearest_palette_color_assert.svh"

module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int PALETTE_SIZE = NPC_PALETTE_SIZE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [NPC_CHAN_W-1:0]  req_pixel_red,
   input  logic [NPC_CHAN_W-1:0]  req_pixel_green,
   input  logic [NPC_CHAN_W-1:0]  req_pixel_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [NPC_INDEX_W-1:0] rsp_best_index,
   output logic [NPC_DIST_W-1:0]  rsp_best_distance_sq
);

   localparam int NUM_CELLS = (PALETTE_SIZE < 1) ? 1 :
                              (PALETTE_SIZE > NPC_ROM_DEPTH) ? NPC_ROM_DEPTH : PALETTE_SIZE;

   logic         advance;
   logic         cell_valid [NUM_CELLS];
   npc_beat_type cell_beat  [NUM_CELLS];
   npc_beat_type head_beat;

   // chain moves unless the last cell holds a result nobody takes
   assign advance   = !cell_valid[NUM_CELLS-1] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      head_beat.red        = req_pixel_red;
      head_beat.green      = req_pixel_green;
      head_beat.blue       = req_pixel_blue;
      // above every reachable distance, so the first entry is always taken
      head_beat.best_dist  = '1;
      head_beat.best_index = NPC_INDEX_W'(1);
   end

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
         npc_cell #(.CELL_INDEX(k)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (req_valid),
            .in_beat   (head_beat),
            .out_valid (cell_valid[k]),
            .out_beat  (cell_beat[k])
         );
      end else begin : g_body
         npc_cell #(.CELL_INDEX(k)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (cell_valid[k-1]),
            .in_beat   (cell_beat[k-1]),
            .out_valid (cell_valid[k]),
            .out_beat  (cell_beat[k])
         );
      end
   end

   assign rsp_valid            = cell_valid[NUM_CELLS-1];
   assign rsp_best_index       = cell_beat[NUM_CELLS-1].best_index;
   assign rsp_best_distance_sq = cell_beat[NUM_CELLS-1].best_dist;

   `NPC_ASSERT_NXT(a_accept_enters_chain, clock, reset, req_valid && req_ready, cell_valid[0])
   `NPC_ASSERT_NXT(a_stall_holds_head, clock, reset, !advance,
                   cell_valid[0] == $past(cell_valid[0]))
   `NPC_ASSERT_IMP(a_index_in_range, clock, reset, rsp_valid,
                   rsp_best_index >= NPC_INDEX_W'(1) &&
                   rsp_best_index <= NPC_INDEX_W'(NUM_CELLS))
   `NPC_ASSERT_IMP(a_distance_in_range, clock, reset, rsp_valid,
                   rsp_best_distance_sq <= NPC_DIST_MAX)

endmodule

FILE: hw/rtl/npc_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npc_cell
// One palette entry: forms the squared distance to the passing pixel and
// keeps the nearer of that entry and the best seen upstream.
// ---------------------------------------------------------------------------
module npc_cell
   import npc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  npc_beat_type in_beat,
   output logic         out_valid,
   output npc_beat_type out_beat
);

   localparam logic [3*NPC_CHAN_W-1:0] COLOR = NPC_PALETTE[CELL_INDEX];
   localparam logic [NPC_INDEX_W-1:0]  ENTRY = NPC_INDEX_W'(CELL_INDEX + 1);

   logic                  valid_ff;
   npc_beat_type          beat_ff;
   npc_beat_type          beat_in;
   logic [NPC_SQ_W-1:0]   sq_red;
   logic [NPC_SQ_W-1:0]   sq_green;
   logic [NPC_SQ_W-1:0]   sq_blue;
   logic [NPC_DIST_W-1:0] sum_sq;
   logic [NPC_CHAN_W-1:0] diff_red;
   logic [NPC_CHAN_W-1:0] diff_green;
   logic [NPC_CHAN_W-1:0] diff_blue;

   always_comb begin
      diff_red   = npc_abs_diff(in_beat.red,   COLOR[23:16]);
      diff_green = npc_abs_diff(in_beat.green, COLOR[15:8]);
      diff_blue  = npc_abs_diff(in_beat.blue,  COLOR[7:0]);
      sq_red     = NPC_SQ_W'(diff_red)   * NPC_SQ_W'(diff_red);
      sq_green   = NPC_SQ_W'(diff_green) * NPC_SQ_W'(diff_green);
      sq_blue    = NPC_SQ_W'(diff_blue)  * NPC_SQ_W'(diff_blue);
      sum_sq     = NPC_DIST_W'(sq_red) + NPC_DIST_W'(sq_green) + NPC_DIST_W'(sq_blue);
      beat_in    = in_beat;
      // less-or-equal: on a tie the later (higher) entry wins
      if (sum_sq <= in_beat.best_dist) begin
         beat_in.best_dist  = sum_sq;
         beat_in.best_index = ENTRY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule
